// File: rtl/interrupt_vector_allocator_core_assert.svh
// assertion macros for the interrupt vector allocator
// every property is sampled on clk and disabled while arst_n is low
`ifndef INTERRUPT_VECTOR_ALLOCATOR_CORE_ASSERT_SVH
`define INTERRUPT_VECTOR_ALLOCATOR_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define IVAC_ASSERT_SAME(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// consequent checked in the next cycle
`define IVAC_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

// File: rtl/ivac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivac_pkg
// shared types, codes and map helpers for the interrupt vector allocator
// ----------------------------------------------------------------------------
package ivac_pkg;

	localparam int NUM_VECTORS = 256;
	localparam int FIRST_IRQ   = 32;
	localparam int WORD_BITS   = 64;
	localparam int MAP_WORDS   = (NUM_VECTORS + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BND_W       = $clog2(NUM_VECTORS);
	localparam int OFF_W       = 6;
	localparam int LOG_W       = 3;
	localparam int SIZE_W      = 7;
	localparam int VEC_W       = 8;
	localparam int STAT_W      = 3;
	localparam int LIMIT_W     = 9;

	localparam logic [LIMIT_W-1:0] APIC_LIMIT_RESET = 9'd240;

	// commands
	localparam logic [1:0] CMD_RESERVE  = 2'd0;
	localparam logic [1:0] CMD_REGISTER = 2'd1;
	localparam logic [1:0] CMD_CLAIM    = 2'd2;
	localparam logic [1:0] CMD_RELEASE  = 2'd3;

	// result status
	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_NO_FREE  = 3'd1;
	localparam logic [STAT_W-1:0] ST_BAD_SIZE = 3'd2;
	localparam logic [STAT_W-1:0] ST_BOUND    = 3'd3;
	localparam logic [STAT_W-1:0] ST_UNBOUND  = 3'd4;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [SIZE_W-1:0] block_size;
		logic [VEC_W-1:0]  vector;
	} ivac_in_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VEC_W-1:0]  base_vector;
	} ivac_out_t;

	// map and flag update command from the sequencer to the store
	typedef struct packed {
		logic                 free_clr;
		logic                 free_set;
		logic [WORD_W-1:0]    word;
		logic [WORD_BITS-1:0] mask;
		logic                 bnd_wr;
		logic                 bnd_val;
		logic [BND_W-1:0]     bnd_idx;
	} ivac_upd_t;

	// bits of a map word that stand for existing vectors
	function automatic logic [WORD_BITS-1:0] word_valid(input logic [WORD_W-1:0] w);
		logic [WORD_BITS-1:0] m;
		int lo;
		lo = int'(w) * WORD_BITS;
		for (int b = 0; b < WORD_BITS; b++) begin
			m[b] = ((lo + b) < NUM_VECTORS);
		end
		return m;
	endfunction

	// reset content of a map word: existing vectors free, exception range taken
	function automatic logic [WORD_BITS-1:0] reset_word(input int w);
		logic [WORD_BITS-1:0] m;
		for (int b = 0; b < WORD_BITS; b++) begin
			m[b] = ((w * WORD_BITS + b) < NUM_VECTORS) && ((w * WORD_BITS + b) >= FIRST_IRQ);
		end
		return m;
	endfunction

endpackage

// File: rtl/ivac_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivac_scan
// aligned block finder: lowest fully free aligned slot of 2**k bits in a word
// ----------------------------------------------------------------------------
module ivac_scan import ivac_pkg::*; (
	input  logic [WORD_BITS-1:0] word,
	input  logic [LOG_W-1:0]     log_size,
	output logic                 found,
	output logic [OFF_W-1:0]     offset
);

	logic [WORD_BITS-1:0] lv  [0:6];
	logic [WORD_BITS-1:0] spr [0:7];
	logic [WORD_BITS-1:0] start;

	assign lv[0] = word;

	// level k bit i: slot i of 2**k bits all free
	for (genvar k = 1; k < 7; k++) begin : g_lvl
		for (genvar i = 0; i < WORD_BITS; i++) begin : g_bit
			if (i < (WORD_BITS >> k)) begin : g_and
				assign lv[k][i] = lv[k-1][2*i] & lv[k-1][2*i+1];
			end else begin : g_zero
				assign lv[k][i] = 1'b0;
			end
		end
	end

	// spread each level back onto the slot start positions
	for (genvar k = 0; k < 7; k++) begin : g_spr
		for (genvar p = 0; p < WORD_BITS; p++) begin : g_pos
			if ((p & ((1 << k) - 1)) == 0) begin : g_start
				assign spr[k][p] = lv[k][p >> k];
			end else begin : g_none
				assign spr[k][p] = 1'b0;
			end
		end
	end
	assign spr[7] = '0;

	assign start = spr[log_size];
	assign found = |start;

	// lowest start position wins
	always_comb begin
		offset = '0;
		for (int p = WORD_BITS - 1; p >= 0; p--) begin
			if (start[p]) begin
				offset = OFF_W'(p);
			end
		end
	end

endmodule

// File: rtl/ivac_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivac_store
// free map words and per-vector bound flags
// ----------------------------------------------------------------------------
module ivac_store import ivac_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [WORD_W-1:0]    rd_word,
	output logic [WORD_BITS-1:0] rd_data,
	input  logic [BND_W-1:0]     bnd_rd_idx,
	output logic                 bnd_rd,
	input  ivac_upd_t            upd
);

	logic [WORD_BITS-1:0]   free_q [MAP_WORDS];
	logic [NUM_VECTORS-1:0] bound_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < MAP_WORDS; w++) begin
				free_q[w] <= reset_word(w);
			end
			bound_q <= '0;
		end else begin
			if (upd.free_clr) begin
				free_q[upd.word] <= free_q[upd.word] & ~upd.mask;
			end else if (upd.free_set) begin
				free_q[upd.word] <= free_q[upd.word] | upd.mask;
			end
			if (upd.bnd_wr) begin
				bound_q[upd.bnd_idx] <= upd.bnd_val;
			end
		end
	end

	// only vectors that exist are ever handed out
	assign rd_data = free_q[rd_word] & word_valid(rd_word);
	assign bnd_rd  = bound_q[bnd_rd_idx];

endmodule

// File: rtl/interrupt_vector_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_vector_allocator_core
// interrupt vector allocator with free bitmap and bound flags
// ----------------------------------------------------------------------------
// Hands out interrupt vectors from a free bitmap of 64-bit words. Each input
// transfer carries one command (reserve an aligned power-of-two block, register
// and bind one vector, claim a given vector, release a vector) and yields
// exactly one output transfer with a status and a vector. Reserve and register
// walk the map one word per cycle through a single aligned-block finder, up to
// the first hit or the end of the map (1 to 4 map words); claim, release and a
// rejected block size skip the walk. The finished result sits in an output
// register, so the next command can be taken while it waits for the consumer.
// The APIC limit register resets to 240 and is written through cfg_we /
// cfg_wdata; the user must write it only while the block is idle, as the
// block does not enforce it. A size-one reserve takes the lowest free vector
// even when it lies at or above the limit and then reports no free block.
// ----------------------------------------------------------------------------
module interrupt_vector_allocator_core import ivac_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ivac_in_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ivac_out_t          out_data,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata
);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} state_t;

	state_t               state_q;
	logic [LIMIT_W-1:0]   apic_limit_q;

	// command held for the whole sequence
	logic [1:0]           cmd_q;
	logic [SIZE_W-1:0]    size_q;
	logic [VEC_W-1:0]     vec_q;
	logic                 bad_q;
	logic [LOG_W-1:0]     log_q;
	logic [WORD_BITS-1:0] blk_q;

	// scan position and hit
	logic [WORD_W-1:0]    word_q;
	logic                 hit_q;
	logic [OFF_W-1:0]     off_q;

	// result register
	logic                 out_valid_q;
	ivac_out_t            out_data_q;

	logic                 in_xfer;
	logic                 out_free;
	logic                 apply_go;
	logic [WORD_BITS-1:0] map_word;
	logic                 scan_found;
	logic [OFF_W-1:0]     scan_off;
	logic                 bnd_rd;
	logic [BND_W-1:0]     bnd_rd_idx;
	ivac_upd_t            upd;
	ivac_out_t            res;

	// decoded incoming size
	logic                 in_bad;
	logic [LOG_W-1:0]     in_log;
	logic [WORD_BITS-1:0] in_blk;

	logic [VEC_W-1:0]     hit_vec;
	logic                 vec_ok;
	logic                 ctrl_cmd;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign apply_go  = (state_q == S_APPLY) && out_free;

	// size decode: reject zero and non powers of two, register always uses one
	always_comb begin
		in_bad = (in_data.block_size == '0) ||
			((in_data.block_size & (in_data.block_size - SIZE_W'(1))) != '0);
		in_log = '0;
		for (int i = 0; i < SIZE_W; i++) begin
			if (in_data.block_size[i]) begin
				in_log = LOG_W'(i);
			end
		end
		if (in_data.cmd == CMD_REGISTER) begin
			in_log = '0;
		end
		if (in_log == LOG_W'(OFF_W)) begin
			in_blk = '1;
		end else begin
			in_blk = (WORD_BITS'(1) << (WORD_BITS'(1) << in_log)) - WORD_BITS'(1);
		end
	end

	ivac_store u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_word    (word_q),
		.rd_data    (map_word),
		.bnd_rd_idx (bnd_rd_idx),
		.bnd_rd     (bnd_rd),
		.upd        (upd)
	);

	ivac_scan u_scan (
		.word     (map_word),
		.log_size (log_q),
		.found    (scan_found),
		.offset   (scan_off)
	);

	assign hit_vec  = VEC_W'({word_q, off_q});
	assign vec_ok   = ({1'b0, vec_q} < LIMIT_W'(NUM_VECTORS));
	assign ctrl_cmd = (cmd_q == CMD_CLAIM) || (cmd_q == CMD_RELEASE);
	assign bnd_rd_idx = ctrl_cmd ? vec_q[BND_W-1:0] : hit_vec[BND_W-1:0];

	// result and map update of the final step
	always_comb begin
		res.status      = ST_OK;
		res.base_vector = '0;
		upd             = '0;
		upd.word        = word_q;
		upd.mask        = blk_q << off_q;
		upd.bnd_idx     = bnd_rd_idx;
		case (cmd_q)
			CMD_RESERVE: begin
				if (bad_q) begin
					res.status = ST_BAD_SIZE;
				end else if (!hit_q) begin
					res.status = ST_NO_FREE;
				end else if (log_q == '0) begin
					// single vector is taken even past the limit
					upd.free_clr    = 1'b1;
					res.base_vector = hit_vec;
					if ({1'b0, hit_vec} >= apic_limit_q) begin
						res.status = ST_NO_FREE;
					end
				end else if (({1'b0, hit_vec} + LIMIT_W'(size_q)) <= apic_limit_q) begin
					upd.free_clr    = 1'b1;
					res.base_vector = hit_vec;
				end else begin
					res.status = ST_NO_FREE;
				end
			end
			CMD_REGISTER: begin
				if (!hit_q) begin
					res.status = ST_NO_FREE;
				end else begin
					upd.free_clr    = 1'b1;
					res.base_vector = hit_vec;
					if ({1'b0, hit_vec} >= apic_limit_q) begin
						res.status = ST_NO_FREE;
					end else if (bnd_rd) begin
						res.status = ST_BOUND;
					end else begin
						upd.bnd_wr  = 1'b1;
						upd.bnd_val = 1'b1;
					end
				end
			end
			CMD_CLAIM: begin
				res.base_vector = vec_q;
				upd.word        = WORD_W'(vec_q >> OFF_W);
				upd.mask        = WORD_BITS'(1) << vec_q[OFF_W-1:0];
				if (!vec_ok) begin
					res.status = ST_NO_FREE;
				end else if (bnd_rd) begin
					res.status = ST_BOUND;
				end else begin
					upd.free_clr = 1'b1;
					upd.bnd_wr   = 1'b1;
					upd.bnd_val  = 1'b1;
				end
			end
			CMD_RELEASE: begin
				res.base_vector = vec_q;
				upd.word        = WORD_W'(vec_q >> OFF_W);
				upd.mask        = WORD_BITS'(1) << vec_q[OFF_W-1:0];
				if (!vec_ok) begin
					res.status = ST_UNBOUND;
				end else begin
					// freed and unbound whether or not it was bound
					if (!bnd_rd) begin
						res.status = ST_UNBOUND;
					end
					upd.free_set = 1'b1;
					upd.bnd_wr   = 1'b1;
					upd.bnd_val  = 1'b0;
				end
			end
			default: begin
				res.status = ST_OK;
			end
		endcase
		// nothing changes until the result can be stored
		upd.free_clr = upd.free_clr && apply_go;
		upd.free_set = upd.free_set && apply_go;
		upd.bnd_wr   = upd.bnd_wr && apply_go;
	end

	// sequencer, config register and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			apic_limit_q <= APIC_LIMIT_RESET;
		end else begin
			if (cfg_we) begin
				apic_limit_q <= cfg_wdata;
			end
			// loaded by the final step, emptied by a transfer out
			if (apply_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						cmd_q  <= in_data.cmd;
						size_q <= in_data.block_size;
						vec_q  <= in_data.vector;
						bad_q  <= in_bad;
						log_q  <= in_log;
						blk_q  <= in_blk;
						word_q <= '0;
						hit_q  <= 1'b0;
						off_q  <= '0;
						// map walk only for commands that search
						if ((in_data.cmd == CMD_REGISTER) ||
							((in_data.cmd == CMD_RESERVE) && !in_bad)) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_APPLY;
						end
					end
				end
				S_SCAN: begin
					if (scan_found) begin
						hit_q   <= 1'b1;
						off_q   <= scan_off;
						state_q <= S_APPLY;
					end else if (word_q == WORD_W'(MAP_WORDS - 1)) begin
						state_q <= S_APPLY;
					end else begin
						word_q <= word_q + WORD_W'(1);
					end
				end
				S_APPLY: begin
					if (out_free) begin
						out_data_q <= res;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/ivac_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivac_checker
// port-level checks for the interrupt vector allocator
// ----------------------------------------------------------------------------
`include "interrupt_vector_allocator_core_assert.svh"

module ivac_checker import ivac_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input ivac_in_t           in_data,
	input logic               out_valid,
	input logic               out_stall,
	input ivac_out_t          out_data
);

	// a held result keeps its payload
	`IVAC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

	// one command at a time: busy right after a transfer in
	`IVAC_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall)

	// status codes stay within the defined set
	`IVAC_ASSERT_SAME(a_status_code, out_valid, out_data.status <= ST_UNBOUND)

	// a rejected size never names a vector
	`IVAC_ASSERT_SAME(a_bad_size_base, out_valid && (out_data.status == ST_BAD_SIZE), out_data.base_vector == '0)

endmodule

bind interrupt_vector_allocator_core ivac_checker u_ivac_checker (.*);
